>>> rtl/text_line_formatter_macros.svh
// Assertion macros shared by the formatter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TEXT_LINE_FORMATTER_MACROS_SVH
`define TEXT_LINE_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tlf_pkg.sv
// Shared types and constants for the text line formatter.
// No dependencies; used by the front, queue, back-end and top-level RTL files.
package tlf_pkg;

    localparam int DEF_NUMBER_DIGITS = 6;
    localparam int DEF_QUEUE_DEPTH   = 2;
    localparam int MODE_W            = 6;

    // mode_flags bit positions
    localparam int FLAG_NONBLANK = 0;
    localparam int FLAG_ENDS     = 1;
    localparam int FLAG_ALL      = 2;
    localparam int FLAG_SQUEEZE  = 3;
    localparam int FLAG_TABS     = 4;
    localparam int FLAG_NONPRINT = 5;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_QMARK     = 8'h3F;
    localparam logic [7:0] CH_I         = 8'h49;
    localparam logic [7:0] CH_M         = 8'h4D;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CTRL_MAX     = 8'h1F;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] META_LO      = 8'h80;
    localparam logic [7:0] META_HI      = 8'h9F;
    localparam logic [7:0] CARET_OFFSET = 8'h40;

    // length of the character expansion
    typedef enum logic [1:0] {
        EXP_ONE,
        EXP_TWO,
        EXP_FOUR
    } exp_len_t;

    // one decoded item as handed from front to back
    typedef struct packed {
        logic       number_en;
        exp_len_t   len;
        logic [7:0] first;
        logic [7:0] last;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_START,
        BK_NUM,
        BK_CHR
    } back_state_t;

endpackage

>>> rtl/tlf_stream_if.sv
// Valid/ready channel interfaces for the formatter input and output items.
// No dependencies.
interface tlf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface tlf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> rtl/tlf_front.sv
// Front end: accepts input items, tracks line state and the BCD line count,
// and decodes each item into a command for the back end. Uses tlf_pkg.
module tlf_front #(
    parameter int NUMBER_DIGITS = tlf_pkg::DEF_NUMBER_DIGITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tlf_pkg::MODE_W-1:0]    mode_flags,
    tlf_in_if.sink                        src,
    input  logic                          q_full,
    output logic                          push_valid,
    output tlf_pkg::cmd_t                 push_cmd,
    output logic [4*NUMBER_DIGITS-1:0]    push_digits
);
    import tlf_pkg::*;

    localparam int ND = NUMBER_DIGITS;

    logic [4*ND-1:0] bcd_reg, bcd_next, bcd_inc;
    logic            line_start_reg, line_start_next;
    logic            prev_blank_reg, prev_blank_next;

    logic            accept, emit, number_en;
    logic            nb, all_lines, np;
    logic [7:0]      c;
    cmd_t            cmd;

    assign src.ready = !q_full;
    assign accept    = src.valid && src.ready;
    assign c         = src.data_byte;

    // BCD increment, ripple carry over the digits
    always_comb
    begin
        logic       carry;
        logic [3:0] d;
        carry   = 1'b1;
        bcd_inc = bcd_reg;
        for (int i = 0; i < ND; i++)
        begin
            d = bcd_reg[4*i +: 4];
            if (carry)
            begin
                if (d == 4'd9)
                begin
                    bcd_inc[4*i +: 4] = 4'd0;
                end
                else
                begin
                    bcd_inc[4*i +: 4] = d + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        nb        = mode_flags[FLAG_NONBLANK];
        all_lines = mode_flags[FLAG_ALL] && !nb;
        np        = mode_flags[FLAG_NONPRINT];

        emit            = 1'b1;
        number_en       = 1'b0;
        line_start_next = line_start_reg;
        prev_blank_next = prev_blank_reg;

        if (line_start_reg)
        begin
            if (c == CH_LF)
            begin
                emit            = !(mode_flags[FLAG_SQUEEZE] && prev_blank_reg);
                number_en       = all_lines;
                prev_blank_next = 1'b1;
            end
            else
            begin
                number_en       = nb || all_lines;
                line_start_next = 1'b0;
                prev_blank_next = 1'b0;
            end
        end
        else if (c == CH_LF)
        begin
            line_start_next = 1'b1;
        end

        bcd_next = (number_en && emit) ? bcd_inc : bcd_reg;

        if (src.end_of_file)
        begin
            bcd_next        = '0;
            line_start_next = 1'b1;
            prev_blank_next = 1'b0;
        end

        // character expansion
        cmd.number_en = number_en;
        cmd.len       = EXP_ONE;
        cmd.first     = CH_CARET;
        cmd.last      = c;
        if (c == CH_LF && mode_flags[FLAG_ENDS])
        begin
            cmd.len   = EXP_TWO;
            cmd.first = CH_DOLLAR;
        end
        else if (c == CH_TAB && mode_flags[FLAG_TABS])
        begin
            cmd.len  = EXP_TWO;
            cmd.last = CH_I;
        end
        else if (np && c <= CTRL_MAX && c != CH_LF && c != CH_TAB)
        begin
            cmd.len  = EXP_TWO;
            cmd.last = c + CARET_OFFSET;
        end
        else if (np && c == CH_DEL)
        begin
            cmd.len  = EXP_TWO;
            cmd.last = CH_QMARK;
        end
        else if (np && (c inside {[META_LO:META_HI]}))
        begin
            cmd.len  = EXP_FOUR;
            cmd.last = c - CARET_OFFSET;
        end
    end

    assign push_valid  = accept && emit;
    assign push_cmd    = cmd;
    assign push_digits = bcd_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_reg        <= '0;
            line_start_reg <= 1'b1;
            prev_blank_reg <= 1'b0;
        end
        else if (accept)
        begin
            bcd_reg        <= bcd_next;
            line_start_reg <= line_start_next;
            prev_blank_reg <= prev_blank_next;
        end
    end

endmodule

>>> rtl/tlf_fifo.sv
// Short command queue between front and back ends.
// Register-based storage; uses tlf_pkg for the default depth.
module tlf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tlf_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);
    import tlf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/tlf_back.sv
// Back end: walks the queue head command one output byte per cycle, while the output is not
// stalled (line number, tab, then the character expansion), into an output register.
// Uses tlf_pkg and text_line_formatter_macros.svh.
`include "text_line_formatter_macros.svh"

module tlf_back #(
    parameter int NUMBER_DIGITS = tlf_pkg::DEF_NUMBER_DIGITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  tlf_pkg::cmd_t              head_cmd,
    input  logic [4*NUMBER_DIGITS-1:0] head_digits,
    output logic                       pop,
    tlf_out_if.source                  dst
);
    import tlf_pkg::*;

    localparam int ND    = NUMBER_DIGITS;
    localparam int IDX_W = ($clog2(ND + 1) > 2) ? $clog2(ND + 1) : 2;

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    logic             advance, cur_num, fin;
    logic [IDX_W-1:0] cur_idx;
    logic [7:0]       byte_val;
    logic [7:0]       num_chars [ND];

    assign advance = head_valid && (!out_valid_reg || dst.ready);

    // number text, most significant digit first, leading zeros as spaces
    always_comb
    begin
        logic       lead;
        logic [3:0] d;
        lead = 1'b1;
        for (int j = 0; j < ND; j++)
        begin
            d    = head_digits[4*(ND-1-j) +: 4];
            lead = lead && (d == 4'd0);
            num_chars[j] = (lead && j != ND - 1) ? CH_SPACE : (CH_ZERO + {4'd0, d});
        end
    end

    always_comb
    begin
        cur_num  = (state_reg == BK_NUM) || (state_reg == BK_START && head_cmd.number_en);
        cur_idx  = (state_reg == BK_START) ? '0 : idx_reg;
        byte_val = head_cmd.last;
        fin      = 1'b1;

        if (cur_num)
        begin
            byte_val = CH_TAB;
            fin      = 1'b0;
            for (int j = 0; j < ND; j++)
            begin
                if (cur_idx == IDX_W'(j))
                begin
                    byte_val = num_chars[j];
                end
            end
        end
        else
        begin
            case (head_cmd.len)
                EXP_ONE:
                begin
                    byte_val = head_cmd.last;
                    fin      = 1'b1;
                end
                EXP_TWO:
                begin
                    byte_val = (cur_idx == '0) ? head_cmd.first : head_cmd.last;
                    fin      = (cur_idx == IDX_W'(1));
                end
                EXP_FOUR:
                begin
                    fin = (cur_idx == IDX_W'(3));
                    if (cur_idx == '0)
                    begin
                        byte_val = CH_M;
                    end
                    else if (cur_idx == IDX_W'(1))
                    begin
                        byte_val = CH_DASH;
                    end
                    else if (cur_idx == IDX_W'(2))
                    begin
                        byte_val = CH_CARET;
                    end
                    else
                    begin
                        byte_val = head_cmd.last;
                    end
                end
                default:
                begin
                    byte_val = head_cmd.last;
                    fin      = 1'b1;
                end
            endcase
        end

        state_next = state_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        if (advance)
        begin
            if (cur_num)
            begin
                if (cur_idx == IDX_W'(ND))
                begin
                    state_next = BK_CHR;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = BK_NUM;
                    idx_next   = cur_idx + IDX_W'(1);
                end
            end
            else if (fin)
            begin
                state_next = BK_START;
                idx_next   = '0;
                pop        = 1'b1;
            end
            else
            begin
                state_next = BK_CHR;
                idx_next   = cur_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_START;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dst.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_val;
            out_last_reg <= !cur_num && fin;
        end
    end

    assign dst.valid       = out_valid_reg;
    assign dst.out_byte    = out_byte_reg;
    assign dst.last_of_run = out_last_reg;

    `TLF_ASSERT_IMPL(a_busy_has_head, clk, rst_n, state_reg != BK_START, head_valid, "command left queue mid-run")
    `TLF_ASSERT_IMPL(a_num_idx_range, clk, rst_n, state_reg == BK_NUM, idx_reg <= IDX_W'(ND), "number index out of range")
    `TLF_ASSERT_NEXT(a_pop_restarts, clk, rst_n, pop, state_reg == BK_START, "no restart after command end")
    `TLF_ASSERT_NEXT(a_adv_loads_out, clk, rst_n, advance, out_valid_reg, "issued byte not held in output")

endmodule

>>> rtl/text_line_formatter.sv
// An accepted item is written into the queue, then its first byte is loaded into the output register.
// Throughput: one item per cycle while each item yields at most one byte and output is not stalled;
// an item with k bytes (up to NUMBER_DIGITS+5) holds the back-end sequencer until all k are out,
// and input stalls once the queue fills.
// Reset (rst_n, async, active low): mode flags 0, line count 0, at line start, queue and output empty.
// Top level of the text line formatter: front decoder, command queue, back-end byte sequencer.
module text_line_formatter #(
    parameter int NUMBER_DIGITS = tlf_pkg::DEF_NUMBER_DIGITS,
    parameter int QUEUE_DEPTH   = tlf_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [tlf_pkg::MODE_W-1:0] cfg_wr_data,
    tlf_in_if.sink                     text_in,
    tlf_out_if.source                  text_out
);
    import tlf_pkg::*;

    localparam int DIG_W = 4 * NUMBER_DIGITS;
    localparam int CMD_W = $bits(cmd_t);
    localparam int Q_W   = DIG_W + CMD_W;

    // mode register; to be written only while the block is idle (the user's duty, not enforced here)
    logic [MODE_W-1:0] mode_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_flags_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            mode_flags_reg <= cfg_wr_data;
        end
    end

    // front -> queue
    logic             push_valid, q_full;
    cmd_t             push_cmd;
    logic [DIG_W-1:0] push_digits;

    // queue -> back
    logic             head_valid, pop;
    logic [Q_W-1:0]   head_data;
    cmd_t             head_cmd;
    logic [DIG_W-1:0] head_digits;

    // Front: line state, squeeze decision, BCD count and expansion decode.
    tlf_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode_flags  (mode_flags_reg),
        .src         (text_in),
        .q_full      (q_full),
        .push_valid  (push_valid),
        .push_cmd    (push_cmd),
        .push_digits (push_digits)
    );

    // Queue decouples front acceptance from the multi-byte back-end runs.
    tlf_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .wr_data  ({push_digits, push_cmd}),
        .full     (q_full),
        .pop      (pop),
        .rd_valid (head_valid),
        .rd_data  (head_data)
    );

    assign head_cmd    = cmd_t'(head_data[CMD_W-1:0]);
    assign head_digits = head_data[Q_W-1:CMD_W];

    // Back: one output byte per cycle into the output register while the output is not stalled.
    tlf_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .head_digits (head_digits),
        .pop         (pop),
        .dst         (text_out)
    );

endmodule

>>> tb/sv/tlf_format_checker.sv
// Output checker for the text line formatter: predicts formatted bytes per input item.
// Depends on tlf_pkg and the tlf_in_if / tlf_out_if channel interfaces.
module tlf_format_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [tlf_pkg::MODE_W-1:0] cfg_wr_data,
    tlf_in_if                          text_in,
    tlf_out_if                         text_out,
    output int                         pending,
    output int                         errors
);
    import tlf_pkg::*;

    localparam int DIGITS = DEF_NUMBER_DIGITS;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_char_t;

    out_char_t               expected_chars[$];
    logic [MODE_W-1:0]       mode;
    logic [4*DIGITS-1:0]     line_bcd;
    logic                    at_start;
    logic                    prev_blank;
    int                      err_tally;

    task automatic emit(input logic [7:0] ch);
        out_char_t e;
        e.ch   = ch;
        e.last = 1'b0;
        expected_chars.push_back(e);
    endtask

    // bump the BCD count, then print it space padded, then a tab
    task automatic emit_number();
        int         i;
        logic       carry;
        logic       leading;
        logic [3:0] d;
        carry = 1'b1;
        for (i = 0; i < DIGITS; i++)
        begin
            if (carry)
            begin
                d = line_bcd[4*i +: 4];
                if (d < 4'd9)
                begin
                    line_bcd[4*i +: 4] = d + 4'd1;
                    carry = 1'b0;
                end
                else
                    line_bcd[4*i +: 4] = 4'd0;
            end
        end
        leading = 1'b1;
        for (i = DIGITS - 1; i >= 0; i--)
        begin
            d = line_bcd[4*i +: 4];
            if (leading && d == 4'd0 && i > 0)
                emit(CH_SPACE);
            else
            begin
                leading = 1'b0;
                emit(CH_ZERO + {4'd0, d});
            end
        end
        emit(CH_TAB);
    endtask

    task automatic emit_char(input logic [7:0] c);
        logic np;
        np = mode[FLAG_NONPRINT];
        if (c == CH_LF && mode[FLAG_ENDS])
        begin
            emit(CH_DOLLAR);
            emit(CH_LF);
        end
        else if (c == CH_TAB && mode[FLAG_TABS])
        begin
            emit(CH_CARET);
            emit(CH_I);
        end
        else if (c <= CTRL_MAX && np && c != CH_LF && c != CH_TAB)
        begin
            emit(CH_CARET);
            emit(c + CARET_OFFSET);
        end
        else if (c == CH_DEL && np)
        begin
            emit(CH_CARET);
            emit(CH_QMARK);
        end
        else if (c >= META_LO && c <= META_HI && np)
        begin
            emit(CH_M);
            emit(CH_DASH);
            emit(CH_CARET);
            emit(c - CARET_OFFSET);
        end
        else
            emit(c);
    endtask

    task automatic format_byte(input logic [7:0] c, input logic eof);
        logic      nb;
        logic      all;
        int        base;
        out_char_t tail;
        nb   = mode[FLAG_NONBLANK];
        all  = mode[FLAG_ALL] && !nb;
        base = expected_chars.size();
        if (at_start)
        begin
            if (c == CH_LF)
            begin
                // blank line; dropped when squeezing a run
                if (!(mode[FLAG_SQUEEZE] && prev_blank))
                begin
                    if (all)
                        emit_number();
                    emit_char(c);
                end
                prev_blank = 1'b1;
            end
            else
            begin
                if (nb || all)
                    emit_number();
                emit_char(c);
                at_start   = 1'b0;
                prev_blank = 1'b0;
            end
        end
        else
        begin
            emit_char(c);
            if (c == CH_LF)
                at_start = 1'b1;
        end
        if (expected_chars.size() > base)
        begin
            tail      = expected_chars[expected_chars.size() - 1];
            tail.last = 1'b1;
            expected_chars[expected_chars.size() - 1] = tail;
        end
        if (eof)
        begin
            line_bcd   = '0;
            at_start   = 1'b1;
            prev_blank = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_char_t exp_c;
        if (!rst_n)
        begin
            mode       = '0;
            line_bcd   = '0;
            at_start   = 1'b1;
            prev_blank = 1'b0;
            err_tally  = 0;
            expected_chars.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (text_out.valid && text_out.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected output item: out_byte %02h last_of_run %0b",
                           text_out.out_byte, text_out.last_of_run);
                    err_tally++;
                end
                else
                begin
                    exp_c = expected_chars.pop_front();
                    if (text_out.out_byte !== exp_c.ch)
                    begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               exp_c.ch, text_out.out_byte);
                        err_tally++;
                    end
                    if (text_out.last_of_run !== exp_c.last)
                    begin
                        $error("last_of_run mismatch: expected %0b, actual %0b",
                               exp_c.last, text_out.last_of_run);
                        err_tally++;
                    end
                end
            end
            if (text_in.valid && text_in.ready)
                format_byte(text_in.data_byte, text_in.end_of_file);
            if (cfg_wr_en)
                mode = cfg_wr_data;
            pending <= expected_chars.size();
            errors  <= err_tally;
        end
    end

endmodule

>>> tb/sv/tb_text_line_formatter.sv
// Top of the text line formatter testbench: clock, reset, stimulus, receiver stalls, verdict.
// Depends on tlf_pkg, the channel interfaces, the formatter RTL and tlf_format_checker.
module tb_text_line_formatter;
    import tlf_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_TAIL     = 16;     // covers items that leave no output bytes
    localparam int LONG_HOLD      = 300;    // receiver hold-off, long enough to fill the queue
    localparam int CARRY_LINES    = 12;     // walks the count past 9
    localparam int TIMEOUT_CYCLES = 400000;

    // mode_flags masks
    localparam logic [MODE_W-1:0] M_NONBLANK = MODE_W'(1 << FLAG_NONBLANK);
    localparam logic [MODE_W-1:0] M_ENDS     = MODE_W'(1 << FLAG_ENDS);
    localparam logic [MODE_W-1:0] M_ALL      = MODE_W'(1 << FLAG_ALL);
    localparam logic [MODE_W-1:0] M_SQUEEZE  = MODE_W'(1 << FLAG_SQUEEZE);
    localparam logic [MODE_W-1:0] M_TABS     = MODE_W'(1 << FLAG_TABS);
    localparam logic [MODE_W-1:0] M_NONPRINT = MODE_W'(1 << FLAG_NONPRINT);
    localparam logic [MODE_W-1:0] M_NONE     = '0;
    localparam logic [MODE_W-1:0] M_EVERY    = '1;

    // receiver stall styles
    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PATTERN
    } rx_style_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [MODE_W-1:0] cfg_wr_data;
    int                pending;
    int                errors;

    int                burst_left;
    bit                gaps_on;
    int                hold_requests;
    int                holds_served;

    tlf_in_if  text_in ();
    tlf_out_if text_out ();

    text_line_formatter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .text_in     (text_in),
        .text_out    (text_out)
    );

    tlf_format_checker fmt_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .text_in     (text_in),
        .text_out    (text_out),
        .pending     (pending),
        .errors      (errors)
    );

    initial
        clk = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: switches between randomly chosen stall styles. A hold
    // request from the stimulus makes it drop ready for a long hold-off set by LONG_HOLD.
    initial
    begin : receiver
        rx_style_t  style;
        int         span;
        logic [7:0] pat;
        text_out.ready = 1'b0;
        holds_served   = 0;
        style          = RX_OPEN;
        span           = 0;
        pat            = 8'b1011_0010;
        forever
        begin
            if (hold_requests != holds_served)
            begin
                holds_served++;
                text_out.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    style = rx_style_t'($urandom_range(0, 4));
                    span  = $urandom_range(16, 64);
                end
                span--;
                case (style)
                    RX_OPEN:   text_out.ready <= 1'b1;
                    RX_HALF:   text_out.ready <= ($urandom_range(0, 1) == 1);
                    RX_MOSTLY: text_out.ready <= ($urandom_range(0, 7) != 0);
                    RX_SPARSE: text_out.ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        text_out.ready <= pat[0];
                        pat = {pat[0], pat[7:1]};
                    end
                endcase
                @(posedge clk);
            end
        end
    end

    // Offer one item; returns right after the edge that accepts it. Valid
    // stays high so back-to-back items need no second assignment per step.
    task automatic send_item(input logic [7:0] b, input logic eof);
        int gap;
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                gap = $urandom_range(0, 6);
                if (gap > 0)
                begin
                    text_in.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        text_in.valid       <= 1'b1;
        text_in.data_byte   <= b;
        text_in.end_of_file <= eof;
        @(posedge clk);
        while (!text_in.ready)
            @(posedge clk);
    endtask

    // Stop offering and wait until the checker holds no more expected bytes,
    // plus a tail for trailing items that produce nothing.
    task automatic drain();
        text_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly text-like bytes, weighted toward the ones that get expanded.
    function automatic logic [7:0] pick_char();
        int         roll;
        logic [7:0] ch;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            ch = 8'($urandom_range(32, 126));
        else if (roll < 55)
            ch = CH_TAB;
        else if (roll < 70)
            ch = 8'($urandom_range(0, 31));
        else if (roll < 75)
            ch = CH_DEL;
        else if (roll < 85)
            ch = 8'($urandom_range(128, 159));
        else if (roll < 95)
            ch = 8'($urandom_range(160, 255));
        else
            ch = 8'($urandom);
        return ch;
    endfunction

    // Random text: mostly whole lines, some blank-line runs (squeeze),
    // some files ending mid-line, and a little pure noise.
    task automatic send_text(input int n);
        int         sent;
        int         len;
        int         kind;
        int         k;
        logic [7:0] raw;
        sent = 0;
        while (sent < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                len = $urandom_range(0, 8);
                for (k = 0; k < len; k++)
                begin
                    send_item(pick_char(), 1'b0);
                    sent++;
                end
                send_item(CH_LF, $urandom_range(0, 9) == 0);
                sent++;
            end
            else if (kind < 85)
            begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                begin
                    send_item(CH_LF, 1'b0);
                    sent++;
                end
            end
            else if (kind < 92)
            begin
                len = $urandom_range(1, 5);
                for (k = 0; k < len; k++)
                begin
                    send_item(pick_char(), k == len - 1);
                    sent++;
                end
            end
            else
            begin
                raw = 8'($urandom);
                send_item(raw, $urandom_range(0, 3) == 0);
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        int                ph;
        int                k;
        logic [MODE_W-1:0] m;
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        text_in.valid       = 1'b0;
        text_in.data_byte   = 8'h00;
        text_in.end_of_file = 1'b0;
        burst_left          = 0;
        gaps_on             = 1'b1;
        hold_requests       = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset mode: everything passes through untouched
        send_item(CH_TAB, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(META_LO, 1'b0);
        send_item(CH_LF, 1'b0);
        drain();

        // every flag: nonblank numbering wins over number-all, blank runs squeezed
        write_mode(M_EVERY);
        send_item(CH_LF, 1'b0);          // blank, not numbered
        send_item(CH_LF, 1'b0);          // second blank, dropped
        send_item("A", 1'b0);            // numbered line
        send_item(CH_TAB, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(CTRL_MAX, 1'b0);
        send_item(CH_DEL, 1'b0);
        send_item(META_LO, 1'b0);
        send_item(META_HI, 1'b0);
        send_item(8'hA0, 1'b0);
        send_item(8'hFF, 1'b0);          // plain byte, not a line end
        send_item(CH_LF, 1'b0);
        send_item("z", 1'b1);            // file ends without a line end
        send_item(CH_LF, 1'b0);          // new file: blank not squeezed
        drain();

        // number-all: blank lines get numbers too
        write_mode(M_ALL);
        send_item(CH_LF, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item("x", 1'b0);
        send_item(CH_LF, 1'b1);          // end of file clears the count
        send_item("y", 1'b0);
        drain();

        // random phases: fixed settings first, both extremes among them, then random settings
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       m = M_EVERY;
                1:       m = M_NONE;
                2:       m = M_ALL | M_SQUEEZE | M_TABS;
                3:       m = M_NONBLANK | M_ENDS | M_NONPRINT;
                default: m = MODE_W'($urandom_range(0, 63));
            endcase
            write_mode(m);
            send_text(8);
            drain();
        end

        // back pressure: receiver holds off while the sender keeps offering
        write_mode(M_EVERY);
        gaps_on    = 1'b0;
        burst_left = 0;
        hold_requests++;
        send_text(24);
        gaps_on = 1'b1;
        drain();

        // numbered file long enough to carry into the tens digit
        write_mode(M_ALL | M_ENDS);
        for (k = 0; k < CARRY_LINES; k++)
            send_item(CH_LF, k == CARRY_LINES - 1);
        drain();

        write_mode(MODE_W'($urandom_range(0, 63)));
        send_text(12);
        drain();

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/tlf_pkg.sv
rtl/tlf_stream_if.sv
rtl/tlf_front.sv
rtl/tlf_fifo.sv
rtl/tlf_back.sv
rtl/text_line_formatter.sv
tb/sv/tlf_format_checker.sv
tb/sv/tb_text_line_formatter.sv
